/* hw/rtl/assert_macros.svh */
// Assertion macros for the encoder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, reset-qualified.
`define B64ENC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the following cycle, reset-qualified.
`define B64ENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/b64enc_pkg.sv */
package b64enc_pkg;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharPad    = 8'h3D;

  localparam logic [5:0] SextetLowerStart = 6'd26;
  localparam logic [5:0] SextetDigitStart = 6'd52;
  localparam logic [5:0] SextetPlus       = 6'd62;

  localparam logic [1:0] GroupOne   = 2'd1;
  localparam logic [1:0] GroupTwo   = 2'd2;
  localparam logic [1:0] GroupThree = 2'd3;

  // One complete or closing group handed from front to back.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } b64enc_group_t;

  typedef struct packed {
    logic          valid;
    b64enc_group_t group;
  } b64enc_push_t;

  typedef struct packed {
    logic          full;
    logic          empty;
    b64enc_group_t head;
  } b64enc_qstat_t;

  // Standard alphabet lookup.
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    logic [7:0] c;
    c = {2'b00, v};
    priority if (v < SextetLowerStart) begin
      return CharUpperA + c;
    end else if (v < SextetDigitStart) begin
      return CharLowerA + c - {2'b00, SextetLowerStart};
    end else if (v < SextetPlus) begin
      return CharDigit0 + c - {2'b00, SextetDigitStart};
    end else if (v == SextetPlus) begin
      return CharPlus;
    end else begin
      return CharSlash;
    end
  endfunction

endpackage

/* hw/rtl/b64enc_if.sv */
interface b64enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64enc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

/* hw/rtl/b64enc_front.sv */
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [7:0]   in_byte_i,
  input  logic         in_eom_i,
  output logic         in_ready_o,
  input  logic         q_full_i,
  output b64enc_push_t push_o
);

  logic [1:0]  count_q, count_d;
  logic [15:0] bytes_q, bytes_d;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    count_d           = count_q;
    bytes_d           = bytes_q;
    push_o.valid      = 1'b0;
    push_o.group.last = in_eom_i;
    unique case (count_q)
      2'd0: begin
        push_o.group.bits   = {in_byte_i, 16'h0000};
        push_o.group.nbytes = GroupOne;
      end
      2'd1: begin
        push_o.group.bits   = {bytes_q[15:8], in_byte_i, 8'h00};
        push_o.group.nbytes = GroupTwo;
      end
      default: begin
        push_o.group.bits   = {bytes_q, in_byte_i};
        push_o.group.nbytes = GroupThree;
      end
    endcase
    if (accept) begin
      if (count_q[1] || in_eom_i) begin
        push_o.valid = 1'b1;
        count_d      = 2'd0;
        bytes_d      = 16'h0000;
      end else if (count_q == 2'd0) begin
        count_d = 2'd1;
        bytes_d = {in_byte_i, 8'h00};
      end else begin
        count_d = 2'd2;
        bytes_d = {bytes_q[15:8], in_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      bytes_q <= 16'h0000;
    end else begin
      count_q <= count_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

/* hw/rtl/b64enc_queue.sv */
module b64enc_queue
  import b64enc_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b64enc_push_t  push_i,
  input  logic          pop_i,
  output b64enc_qstat_t stat_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  b64enc_group_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.head  = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.group;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* hw/rtl/b64enc_back.sv */
module b64enc_back
  import b64enc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b64enc_qstat_t stat_i,
  output logic          pop_o,
  output logic          out_valid_o,
  output logic [7:0]    out_char_o,
  output logic          out_last_o,
  input  logic          out_ready_i
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load;
  logic [5:0] sextet;
  logic       pad;

  // Refill the output register when it is empty or being drained.
  assign load  = !stat_i.empty && (!valid_q || out_ready_i);
  assign pop_o = load && (idx_q == 2'd3);

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = stat_i.head.bits[23:18];
      2'd1:    sextet = stat_i.head.bits[17:12];
      2'd2:    sextet = stat_i.head.bits[11:6];
      default: sextet = stat_i.head.bits[5:0];
    endcase
    pad = ((idx_q == 2'd2) && (stat_i.head.nbytes < GroupTwo)) ||
          ((idx_q == 2'd3) && (stat_i.head.nbytes < GroupThree));
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (load) begin
      idx_d   = idx_q + 1'b1;
      valid_d = 1'b1;
      char_d  = pad ? CharPad : sextet_to_ascii(sextet);
      last_d  = stat_i.head.last && (idx_q == 2'd3);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

/* hw/rtl/base64_stream_encoder_top.sv */
// Channel   Dir   Payload                           Handshake
// in_i      in    data_byte[7:0], end_of_message    valid/ready
// out_o     out   ascii_char[7:0], last_char        valid/ready
//
// Each group of up to three bytes yields four characters, one per cycle from
// the output register while the output is ready; the sustained rate is set
// by the single-character output register.
// A byte is taken whenever the group queue (QueueDepth) has room.
// Reset is asynchronous and clears the pending bytes, queue and output valid.
// Output stalls back up through the queue; input waits only when it is full.
module base64_stream_encoder_top
  import b64enc_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  b64enc_byte_if.sink  in_i,
  b64enc_char_if.source out_o
);

  b64enc_push_t  push;
  b64enc_qstat_t stat;
  logic          pop;

  b64enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.data_byte),
    .in_eom_i   (in_i.end_of_message),
    .in_ready_o (in_i.ready),
    .q_full_i   (stat.full),
    .push_o     (push)
  );

  b64enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (stat)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_char_o  (out_o.ascii_char),
    .out_last_o  (out_o.last_char),
    .out_ready_i (out_o.ready)
  );

endmodule

/* hw/rtl/b64enc_checker.sv */
`include "assert_macros.svh"

module b64enc_checker
  import b64enc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i
);

  logic out_xfer;
  logic in_alphabet;

  assign out_xfer    = out_valid_i && out_ready_i;
  assign in_alphabet = ((out_char_i >= 8'h41) && (out_char_i <= 8'h5A)) ||
                       ((out_char_i >= 8'h61) && (out_char_i <= 8'h7A)) ||
                       ((out_char_i >= 8'h30) && (out_char_i <= 8'h39)) ||
                       (out_char_i == CharPlus) || (out_char_i == CharSlash) ||
                       (out_char_i == CharPad);

  `B64ENC_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `B64ENC_ASSERT_NEXT(a_char_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_char_i) && $stable(out_last_i))
  `B64ENC_ASSERT_SAME(a_char_legal, clk_i, rst_ni, out_valid_i, in_alphabet)
  // A first pad is followed at once by the closing pad of the same group.
  `B64ENC_ASSERT_NEXT(a_pad_pair, clk_i, rst_ni, out_xfer && (out_char_i == CharPad) && !out_last_i, out_valid_i && (out_char_i == CharPad) && out_last_i)

endmodule

bind base64_stream_encoder_top b64enc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.ascii_char),
  .out_last_i  (out_o.last_char)
);

/* sim/tb_base64_stream_encoder_top.sv */
module tb_base64_stream_encoder_top;
  import b64enc_pkg::*;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned TailCycles  = 24;
  localparam int unsigned MaxReports  = 10;

  // Standard alphabet, index 0 in the top byte.
  localparam logic [8*64-1:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ascii;
    logic       last;
  } encoded_char_t;

  logic clk;
  logic rst_n;

  b64enc_byte_if byte_ch ();
  b64enc_char_if char_ch ();

  base64_stream_encoder_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (char_ch)
  );

  // Encoder state as seen from the byte stream
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  encoded_char_t encoded_chars_q[$];

  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  bit          steady_flow;
  bit          hold_off_req;

  initial clk = 1'b0;
  always #HalfPeriod clk = ~clk;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    int unsigned idx;
    idx = 63 - int'(v);
    return B64Alphabet[8*idx +: 8];
  endfunction

  task automatic push_group(input logic [23:0] grp, input logic [1:0] nbytes,
                            input logic eom);
    encoded_char_t c;
    c.last  = 1'b0;
    c.ascii = sextet_char(grp[23:18]);
    encoded_chars_q = {encoded_chars_q, c};
    c.ascii = sextet_char(grp[17:12]);
    encoded_chars_q = {encoded_chars_q, c};
    c.ascii = (nbytes >= GroupTwo) ? sextet_char(grp[11:6]) : CharPad;
    encoded_chars_q = {encoded_chars_q, c};
    c.ascii = (nbytes >= GroupThree) ? sextet_char(grp[5:0]) : CharPad;
    c.last  = eom;
    encoded_chars_q = {encoded_chars_q, c};
  endtask

  // Advance the group state by one accepted byte.
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    case (held_count)
      2'd0: begin
        if (!eom) begin
          held_bytes = {b, 8'h00};
          held_count = GroupOne;
          return;
        end
        push_group({b, 16'h0000}, GroupOne, 1'b1);
      end
      GroupOne: begin
        if (!eom) begin
          held_bytes[7:0] = b;
          held_count = GroupTwo;
          return;
        end
        push_group({held_bytes[15:8], b, 8'h00}, GroupTwo, 1'b1);
      end
      default: begin
        push_group({held_bytes, b}, GroupThree, eom);
      end
    endcase
    held_bytes = '0;
    held_count = '0;
  endtask

  // Called at a falling edge; returns at a falling edge with valid possibly still high.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int unsigned gap;
    byte_ch.valid          <= 1'b1;
    byte_ch.data_byte      <= b;
    byte_ch.end_of_message <= eom;
    do @(posedge clk); while (!byte_ch.ready);
    encode_byte(b, eom);
    bytes_sent++;
    @(negedge clk);
    gap = 0;
    if (!steady_flow && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    while (encoded_chars_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_message(input int unsigned max_len);
    int unsigned len;
    len = $urandom_range(1, max_len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_full_groups();
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    // Zero group, all-ones group, then the '+' group closing the message
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) send_random_message(40);
      else send_random_message(8);
    end
  endtask

  // Hold the output off long enough that the input backs up and stalls.
  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    for (int unsigned i = 0; i < 45; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 44);
    end
    drain_results();
  endtask

  // Pause with bytes held in an open group, then finish the message.
  task automatic test_pause_mid_message();
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    drain_results();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    drain_results();
  endtask

  initial begin
    rst_n                  = 1'b0;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = '0;
    byte_ch.end_of_message = 1'b0;
    held_bytes             = '0;
    held_count             = '0;
    mismatch_count         = 0;
    bytes_sent             = 0;
    steady_flow            = 1'b0;
    hold_off_req           = 1'b0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_messages();
    test_full_groups();
    test_random_traffic(160);
    test_output_hold_off();
    test_pause_mid_message();
    steady_flow = 1'b1;
    test_random_traffic(80);

    drain_results();
    repeat (TailCycles) @(negedge clk);
    if (mismatch_count == 0 && encoded_chars_q.size() == 0) begin
      $display("tb_base64_stream_encoder_top: PASS");
    end else begin
      $display("tb_base64_stream_encoder_top: FAIL");
    end
    $finish;
  end

  // Output side: random stall bursts, one long hold-off on request
  initial begin
    int unsigned stall;
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        char_ch.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 19);
        char_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        char_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned act_val);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what,
               exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    encoded_char_t want;
    if (rst_n && char_ch.valid && char_ch.ready) begin
      if (encoded_chars_q.size() == 0) begin
        report_mismatch("unexpected character", 0, char_ch.ascii_char);
      end else begin
        want = encoded_chars_q.pop_front();
        if (char_ch.ascii_char !== want.ascii) begin
          report_mismatch("ascii_char", want.ascii, char_ch.ascii_char);
        end
        if (char_ch.last_char !== want.last) begin
          report_mismatch("last_char", want.last, char_ch.last_char);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_base64_stream_encoder_top: FAIL");
        $finish;
      end
    end
  end

endmodule
